// File: design/sleep_wakeup_min_heap_macros.svh
// Assertion macros used by the sleep timer queue port checker.
`ifndef SLEEP_WAKEUP_MIN_HEAP_MACROS_SVH
`define SLEEP_WAKEUP_MIN_HEAP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SWMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SWMH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/swmh_pkg.sv
// Types and constants shared by the sleep timer queue.
`default_nettype none
package swmh_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int TIME_SCALE = 1000;

  localparam int IDX_W   = $clog2(HEAP_DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  localparam int SCALE_W = $clog2(TIME_SCALE + 1);
  localparam int PROD_W  = 15 + SCALE_W;
  localparam int SUM_W   = ((PROD_W > 32) ? PROD_W : 32) + 1;

  localparam logic FUNC_SLEEP = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_REJECTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_WOKEN    = 3'd3,
    ST_NONE_DUE = 3'd4
  } status_t;

  typedef struct packed {
    logic        func;
    logic [5:0]  sleeper_id;
    logic signed [15:0] delay_seconds;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  woken_id;
    logic [6:0]  queue_count;
  } rsp_t;

  typedef struct packed {
    logic [5:0]  id;
    logic [31:0] wake;
  } entry_t;

endpackage
`default_nettype wire

// File: design/sleep_wakeup_min_heap.sv
// Sleep timer queue: binary min-heap of sleeper id and wake time in one RAM.
// Flow: reject, full and empty-heap answers go from S_IDLE straight to S_DONE;
//   a sleep request runs S_MUL, S_ADD, then S_UP_ISSUE and S_UP per level climbed;
//   a wake-up runs S_TOP, S_LAST, then S_DN_ISSUE, S_DN_L (and S_DN_R) per level.
// One item at a time: the input stalls while the single RAM read port walks levels.
// Reset clears the entry count and the output beat; heap RAM needs no clearing.
`default_nettype none
module sleep_wakeup_min_heap (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire swmh_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output swmh_pkg::rsp_t     rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_UP_ISSUE,
    S_UP,
    S_TOP,
    S_LAST,
    S_DN_ISSUE,
    S_DN_L,
    S_DN_R,
    S_DONE
  } state_t;

  state_t                          state;
  logic [swmh_pkg::CNT_W-1:0]      cnt;
  swmh_pkg::req_t                  op;
  swmh_pkg::entry_t                moving;
  swmh_pkg::entry_t                lval;
  logic [swmh_pkg::IDX_W-1:0]      pos;
  logic [swmh_pkg::PROD_W-1:0]     prod;
  swmh_pkg::status_t               res_status;
  logic [5:0]                      res_woken;

  // RAM port
  logic                            ram_we;
  logic [swmh_pkg::IDX_W-1:0]      ram_waddr;
  swmh_pkg::entry_t                ram_wdata;
  logic [swmh_pkg::IDX_W-1:0]      ram_raddr;
  logic [$bits(swmh_pkg::entry_t)-1:0] ram_rdata;
  swmh_pkg::entry_t                rd;

  logic [swmh_pkg::IDX_W-1:0]      parent_idx;
  logic [swmh_pkg::CNT_W-1:0]      child_l;
  logic [swmh_pkg::CNT_W-1:0]      child_r;
  logic [swmh_pkg::CNT_W-1:0]      cnt_dec;
  logic [swmh_pkg::SUM_W-1:0]      sum;
  logic [31:0]                     wake_sat;
  logic                            l_less;
  logic [31:0]                     best_wake;
  logic                            r_best;
  logic                            accept;
  logic                            out_free;

  swmh_ram #(
    .WIDTH($bits(swmh_pkg::entry_t)),
    .DEPTH(swmh_pkg::HEAP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd         = swmh_pkg::entry_t'(ram_rdata);
  assign parent_idx = (pos - swmh_pkg::IDX_W'(1)) >> 1;
  assign child_l    = {pos, 1'b1};
  assign child_r    = child_l + swmh_pkg::CNT_W'(1);
  assign cnt_dec    = cnt - swmh_pkg::CNT_W'(1);

  // Wake time: now plus scaled delay, pinned at the top of the 32-bit range.
  assign sum      = swmh_pkg::SUM_W'(op.now_time) + swmh_pkg::SUM_W'(prod);
  assign wake_sat = (sum[swmh_pkg::SUM_W-1:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];

  // Sift-down pick: left wins only when strictly earlier, right only when
  // strictly earlier than the better of the two others.
  assign l_less    = lval.wake < moving.wake;
  assign best_wake = l_less ? lval.wake : moving.wake;
  assign r_best    = rd.wake < best_wake;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // RAM addressing per state; read data is registered and shows in rd in the next cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = moving;
    ram_raddr = '0;
    case (state)
      S_UP_ISSUE: begin
        if (pos == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_raddr = parent_idx;
        end
      end
      S_UP: begin
        ram_we = 1'b1;
        if (rd.wake > moving.wake) begin
          ram_wdata = rd;
        end
      end
      S_TOP: begin
        ram_raddr = cnt_dec[swmh_pkg::IDX_W-1:0];
      end
      S_DN_ISSUE: begin
        if (child_l < cnt) begin
          ram_raddr = child_l[swmh_pkg::IDX_W-1:0];
        end else begin
          ram_we = 1'b1;
        end
      end
      S_DN_L: begin
        if (child_r < cnt) begin
          ram_raddr = child_r[swmh_pkg::IDX_W-1:0];
        end else begin
          ram_we = 1'b1;
          if (rd.wake < moving.wake) begin
            ram_wdata = rd;
          end
        end
      end
      S_DN_R: begin
        ram_we = 1'b1;
        if (r_best) begin
          ram_wdata = rd;
        end else if (l_less) begin
          ram_wdata = lval;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Raise the output beat when a result leaves; drop it once taken.
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op        <= req;
            res_woken <= '0;
            if (req.func == swmh_pkg::FUNC_TICK) begin
              if (cnt == '0) begin
                res_status <= swmh_pkg::ST_NONE_DUE;
                state      <= S_DONE;
              end else begin
                state <= S_TOP;
              end
            end else if (req.delay_seconds[15]) begin
              res_status <= swmh_pkg::ST_REJECTED;
              state      <= S_DONE;
            end else if (cnt == swmh_pkg::CNT_W'(swmh_pkg::HEAP_DEPTH)) begin
              res_status <= swmh_pkg::ST_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= swmh_pkg::PROD_W'(op.delay_seconds[14:0]) *
                   swmh_pkg::PROD_W'(swmh_pkg::TIME_SCALE);
          pos   <= cnt[swmh_pkg::IDX_W-1:0];
          state <= S_ADD;
        end
        S_ADD: begin
          moving.id   <= op.sleeper_id;
          moving.wake <= wake_sat;
          state       <= S_UP_ISSUE;
        end
        S_UP_ISSUE: begin
          if (pos == '0) begin
            cnt        <= cnt + swmh_pkg::CNT_W'(1);
            res_status <= swmh_pkg::ST_QUEUED;
            state      <= S_DONE;
          end else begin
            state <= S_UP;
          end
        end
        S_UP: begin
          if (rd.wake > moving.wake) begin
            pos   <= parent_idx;
            state <= S_UP_ISSUE;
          end else begin
            cnt        <= cnt + swmh_pkg::CNT_W'(1);
            res_status <= swmh_pkg::ST_QUEUED;
            state      <= S_DONE;
          end
        end
        S_TOP: begin
          if (rd.wake <= op.now_time) begin
            cnt        <= cnt_dec;
            res_woken  <= rd.id;
            res_status <= swmh_pkg::ST_WOKEN;
            state      <= (cnt_dec == '0) ? S_DONE : S_LAST;
          end else begin
            res_status <= swmh_pkg::ST_NONE_DUE;
            state      <= S_DONE;
          end
        end
        S_LAST: begin
          moving <= rd;
          pos    <= '0;
          state  <= S_DN_ISSUE;
        end
        S_DN_ISSUE: begin
          state <= (child_l < cnt) ? S_DN_L : S_DONE;
        end
        S_DN_L: begin
          lval <= rd;
          if (child_r < cnt) begin
            state <= S_DN_R;
          end else if (rd.wake < moving.wake) begin
            pos   <= child_l[swmh_pkg::IDX_W-1:0];
            state <= S_DN_ISSUE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_R: begin
          if (r_best) begin
            pos   <= child_r[swmh_pkg::IDX_W-1:0];
            state <= S_DN_ISSUE;
          end else if (l_less) begin
            pos   <= child_l[swmh_pkg::IDX_W-1:0];
            state <= S_DN_ISSUE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            rsp.status      <= res_status;
            rsp.woken_id    <= res_woken;
            rsp.queue_count <= 7'(cnt);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/swmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module swmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/swmh_checker.sv
// Port-level checker for the sleep timer queue, bound to the top level.
`default_nettype none
`include "sleep_wakeup_min_heap_macros.svh"
module swmh_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire swmh_pkg::rsp_t rsp
);

  `SWMH_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled beat changed")
  `SWMH_ASSERT(a_woken_zero, rsp_valid && rsp.status != swmh_pkg::ST_WOKEN |-> rsp.woken_id == '0, "woken id set without wake")
  `SWMH_ASSERT(a_queued_nonempty, rsp_valid && rsp.status == swmh_pkg::ST_QUEUED |-> rsp.queue_count != '0, "queued beat shows empty heap")
  `SWMH_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "input open right after a beat")
  `SWMH_ASSERT_ALWAYS(a_reset_quiet, $past(rst) && !rst |-> !rsp_valid, "output beat right after reset")

endmodule

bind sleep_wakeup_min_heap swmh_checker u_swmh_checker (.*);
`default_nettype wire

// File: bench/swmh_checker.sv
// Checker for the sleep timer queue: heap predictor and response compare.
`timescale 1ns / 100ps
`default_nettype none
module swmh_scoreboard (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire logic            req_stall,
  input  wire swmh_pkg::req_t  req,
  input  wire logic            rsp_valid,
  input  wire logic            rsp_stall,
  input  wire swmh_pkg::rsp_t  rsp,
  output int                   fail_count,
  output int                   pending,
  output int                   woken_seen,
  output int                   full_seen
);

  swmh_pkg::entry_t heap_q [swmh_pkg::HEAP_DEPTH];
  int               held;
  swmh_pkg::rsp_t   expected_rsp [$];

  function automatic swmh_pkg::rsp_t heap_apply(swmh_pkg::req_t r);
    swmh_pkg::rsp_t   o;
    swmh_pkg::entry_t e;
    swmh_pkg::entry_t t;
    logic [47:0] wake;
    int pos;
    int par;
    int l;
    int b;
    o = '0;
    if (r.func == swmh_pkg::FUNC_SLEEP) begin
      if (r.delay_seconds[15]) begin
        o.status = swmh_pkg::ST_REJECTED;
      end else if (held >= swmh_pkg::HEAP_DEPTH) begin
        o.status = swmh_pkg::ST_FULL;
      end else begin
        wake = 48'(r.now_time) + 48'(r.delay_seconds) * 48'(swmh_pkg::TIME_SCALE);
        if (wake > 48'hFFFF_FFFF) wake = 48'hFFFF_FFFF;
        e.id = r.sleeper_id;
        e.wake = wake[31:0];
        // climb while the parent wakes strictly later
        pos = held;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (heap_q[par].wake <= e.wake) break;
          heap_q[pos] = heap_q[par];
          pos = par;
        end
        heap_q[pos] = e;
        held++;
        o.status = swmh_pkg::ST_QUEUED;
      end
    end else begin
      if (held > 0 && heap_q[0].wake <= r.now_time) begin
        o.status = swmh_pkg::ST_WOKEN;
        o.woken_id = heap_q[0].id;
        held--;
        heap_q[0] = heap_q[held];
        pos = 0;
        forever begin
          l = 2 * pos + 1;
          b = pos;
          if (l < held && heap_q[l].wake < heap_q[b].wake) b = l;
          if (l + 1 < held && heap_q[l + 1].wake < heap_q[b].wake) b = l + 1;
          if (b == pos) break;
          t = heap_q[pos];
          heap_q[pos] = heap_q[b];
          heap_q[b] = t;
          pos = b;
        end
      end else begin
        o.status = swmh_pkg::ST_NONE_DUE;
      end
    end
    o.queue_count = 7'(held);
    return o;
  endfunction

  always @(posedge clk) begin
    swmh_pkg::rsp_t want;
    if (rst) begin
      held <= 0;
      fail_count <= 0;
      woken_seen <= 0;
      full_seen <= 0;
      expected_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected response beat %h", rsp);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status != want.status || rsp.woken_id != want.woken_id ||
              rsp.queue_count != want.queue_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected status %0d id %0d count %0d, got %0d %0d %0d",
                       want.status, want.woken_id, want.queue_count,
                       rsp.status, rsp.woken_id, rsp.queue_count);
          end
          if (rsp.status == swmh_pkg::ST_WOKEN) woken_seen++;
          if (rsp.status == swmh_pkg::ST_FULL) full_seen++;
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(heap_apply(req));
    end
  end

  assign pending = expected_rsp.size();
endmodule
`default_nettype wire

// File: bench/tb_sleep_wakeup_min_heap.sv
// Testbench top for the sleep timer queue: stimulus, idling and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_sleep_wakeup_min_heap;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  swmh_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  swmh_pkg::rsp_t rsp;

  int fail_count;
  int pending;
  int woken_seen;
  int full_seen;

  // Idle percentages per phase; the hold-off flag freezes the receiver.
  int send_idle_pct = 18;
  int recv_idle_pct = 68;
  bit hold_off = 1'b0;
  logic [31:0] clock_now = 32'd0;
  int beats_sent = 0;

  always #5 clk = ~clk;

  sleep_wakeup_min_heap u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  swmh_scoreboard u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .fail_count(fail_count), .pending(pending),
    .woken_seen(woken_seen), .full_seen(full_seen)
  );

  // Stall the response side at random, or solid while the hold-off runs.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one beat and hold it until accepted, with random gaps before it.
  task automatic send_beat(input swmh_pkg::req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_sleep(input logic [5:0] id, input logic [15:0] secs,
                            input logic [31:0] now);
    swmh_pkg::req_t r;
    r.func = swmh_pkg::FUNC_SLEEP;
    r.sleeper_id = id;
    r.delay_seconds = secs;
    r.now_time = now;
    send_beat(r);
  endtask

  task automatic send_tick(input logic [31:0] now, input logic [5:0] junk_id,
                           input logic [15:0] junk_secs);
    swmh_pkg::req_t r;
    r.func = swmh_pkg::FUNC_TICK;
    r.sleeper_id = junk_id;
    r.delay_seconds = junk_secs;
    r.now_time = now;
    send_beat(r);
  endtask

  // Random traffic: short delays around a moving clock so wake-ups are common.
  task automatic random_mix(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      clock_now = clock_now + $urandom_range(3000);
      case ($urandom_range(9))
        0: send_sleep(6'($urandom), 16'($urandom), $urandom);
        1, 2, 3: send_sleep(6'($urandom), 16'($urandom_range(8)), clock_now);
        default: send_tick($urandom_range(3) == 0 ? $urandom : clock_now,
                           6'($urandom), 16'($urandom));
      endcase
    end
  endtask

  // Drain everything queued so later phases start from a known count.
  task automatic drain_heap();
    int k;
    for (k = 0; k < 66; k++) send_tick(32'hFFFF_FFFF, 6'($urandom), 16'($urandom));
  endtask

  initial begin
    int k;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty tick, rejects, saturation, equal wake times, duplicates.
    send_tick(32'hFFFF_FFFF, 6'h3F, 16'h7FFF);
    send_sleep(6'd0, 16'h8000, 32'd0);
    send_sleep(6'h3F, 16'hFFFF, 32'hFFFF_FFFF);
    send_sleep(6'h3F, 16'h7FFF, 32'hFFFF_FFFF);
    send_sleep(6'd1, 16'd0, 32'd0);
    send_sleep(6'd2, 16'd5, 32'd100);
    send_sleep(6'd3, 16'd5, 32'd100);
    send_sleep(6'd2, 16'd1, 32'd0);
    send_tick(32'd0, 6'd0, 16'd0);
    send_tick(32'd999, 6'h3F, 16'hFFFF);
    send_tick(32'd1000, 6'd0, 16'd0);
    send_tick(32'd5100, 6'd0, 16'd0);
    send_tick(32'd5100, 6'd0, 16'd0);
    send_tick(32'hFFFF_FFFE, 6'd0, 16'd0);
    send_tick(32'hFFFF_FFFF, 6'd0, 16'd0);
    send_tick(32'hFFFF_FFFF, 6'd0, 16'd0);

    // Fill to the top and one past it, then empty again.
    for (k = 0; k < 65; k++) send_sleep(k[5:0], 16'($urandom_range(50)), $urandom);
    drain_heap();

    // Pressure: freeze the receiver for a long stretch while beats keep coming.
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_mix(20);
    join

    random_mix(80);
    send_idle_pct = 68;
    recv_idle_pct = 18;
    random_mix(80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_mix(70);

    // Keep going with random traffic until enough sleepers have been woken.
    n = 0;
    while (woken_seen < 60 && n < 500) begin
      random_mix(1);
      n++;
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d beats: rejects, saturation, full heap, ties and receiver hold-off.",
             beats_sent);
    $display("Saw %0d wake-ups and %0d heap-full answers.", woken_seen, full_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+design
design/swmh_pkg.sv
design/swmh_ram.sv
design/sleep_wakeup_min_heap.sv
design/swmh_checker.sv
bench/swmh_checker.sv
bench/tb_sleep_wakeup_min_heap.sv
